/* rtl/gdd_pkg.sv */
// Package with shared widths, constants and the month length table of the date difference block.
`timescale 1ns / 1ps

package gdd_pkg;

  // Field widths of one request and one result.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;

  // Stream bus widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 32;

  // Default upper limit of a valid year.
  localparam int unsigned DEF_MAX_YEAR = 9999;

  // Running sum width: holds any partial day count of two dates with margin.
  localparam int unsigned ACC_W = 25;

  // Shared multiplier: a year plus a small offset times a 13-bit constant.
  localparam int unsigned MUL_A_W = YEAR_W + 1;
  localparam int unsigned MUL_K_W = 13;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_K_W;

  localparam logic [MUL_K_W-1:0] DAYS_PER_YEAR = 13'd365;

  // floor(x / 100) == (x * 5243) >> 19 holds for every x below 43690.
  localparam logic [MUL_K_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam int unsigned        Q100_W      = 8;
  localparam int unsigned        Q400_W      = 6;

  // Offsets that turn the floor quotients into ceiling quotients.
  localparam logic [MUL_A_W-1:0] OFS_LEAP4   = 15'd3;
  localparam logic [MUL_A_W-1:0] OFS_CENT100 = 15'd99;
  localparam logic [MUL_A_W-1:0] OFS_CENT400 = 15'd399;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

  // Saturation bounds of the 23-bit signed day count.
  localparam logic signed [ACC_W-1:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [ACC_W-1:0] DIFF_MIN = -25'sd4194304;

  // Days in a month; month codes outside 1..12 read as 31.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/gregorian_date_difference.sv */
// Top level of the Gregorian date difference block with its sequencer and shared arithmetic.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one request per beat: two calendar dates A and B.
// The master stream returns one result beat per request: a validity flag for
// each date, the signed day count A minus B, and flags for A before B and
// A after B. When either date is invalid the count and both flags are zero.
// Each request is worked through by a small sequencer around one shared
// multiplier and one shared accumulate adder. Per date it works through the
// year terms (365 per year, leap days via reciprocal multiplication), then
// the day, then the preceding months one at a time, at most 12, and a last
// step that closes the loop. The result is loaded in the final step once
// both dates are done and the output register is free. s_tready_o is high
// only while the sequencer is idle, so one request is in work at a time; a
// new request is taken in the cycle after the result has been loaded, even
// while that result still waits on the master side. A stalled receiver
// holds the result steady in the output register; a finished item then
// waits in the final step until the register frees up. Reset empties the
// output register and returns the sequencer to idle; there is no other
// state to clear.
module gregorian_date_difference
  import gdd_pkg::*;
#(
  parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request: day_a[4:0], month_a[8:5], year_a[22:9], day_b[27:23],
  // month_b[31:28], year_b[45:32], zero padding above.
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  // Result: valid_a[0], valid_b[1], day_difference[24:2], a_before_b[25],
  // a_after_b[26], zero padding above.
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o
);

  // Sequencer steps; ST_MUL to ST_MONTH are taken once for date A and once for date B.
  localparam logic [3:0] ST_IDLE  = 4'd0;  // wait for a request
  localparam logic [3:0] ST_MUL   = 4'd1;  // multiply year by 365
  localparam logic [3:0] ST_YEAR  = 4'd2;  // add 365 * y, multiply for /100
  localparam logic [3:0] ST_CENT  = 4'd3;  // drop century days, leap test, multiply for /400
  localparam logic [3:0] ST_QUAD  = 4'd4;  // add back 400-year days
  localparam logic [3:0] ST_FOUR  = 4'd5;  // add four-year leap days
  localparam logic [3:0] ST_DAY   = 4'd6;  // add day of month, check the date
  localparam logic [3:0] ST_MONTH = 4'd7;  // add one preceding month per cycle
  localparam logic [3:0] ST_DONE  = 4'd8;  // saturate and load the result

  localparam logic [YEAR_W+1:0] MaxYearW = (YEAR_W + 2)'(MAX_YEAR);

  logic [3:0] state_q, state_d;
  logic       sel_b_q, sel_b_d;
  logic       out_valid_q, out_valid_d;

  // Captured request.
  logic [DAY_W-1:0]   day_a_q, day_b_q;
  logic [MONTH_W-1:0] month_a_q, month_b_q;
  logic [YEAR_W-1:0]  year_a_q, year_b_q;

  // Working registers.
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0]       prod_q;
  logic [MONTH_W-1:0]      mcnt_q;
  logic                    leap_q;
  logic                    valid_a_q, valid_b_q;

  // Result register.
  logic              out_va_q, out_vb_q, out_bef_q, out_aft_q;
  logic [DIFF_W-1:0] out_diff_q;

  logic in_beat, load_out;

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_beat    = s_tvalid_i && s_tready_o;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || m_tready_i);

  // Fields of the date in work.
  logic [DAY_W-1:0]   cur_d;
  logic [MONTH_W-1:0] cur_m;
  logic [YEAR_W-1:0]  cur_y;

  assign cur_d = sel_b_q ? day_b_q   : day_a_q;
  assign cur_m = sel_b_q ? month_b_q : month_a_q;
  assign cur_y = sel_b_q ? year_b_q  : year_a_q;

  // Shared multiplier with its operand selection.
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_K_W-1:0] mul_k;

  always_comb begin
    case (state_q)
      ST_YEAR: begin
        mul_a = {1'b0, cur_y} + OFS_CENT100;
        mul_k = RECIP_100;
      end
      ST_CENT: begin
        mul_a = {1'b0, cur_y} + OFS_CENT400;
        mul_k = RECIP_100;
      end
      default: begin
        mul_a = {1'b0, cur_y};
        mul_k = DAYS_PER_YEAR;
      end
    endcase
  end

  // Quotients read from the registered product.
  logic [Q100_W-1:0] q100;
  logic [Q400_W-1:0] q400;

  assign q100 = prod_q[RECIP_SHIFT +: Q100_W];
  assign q400 = prod_q[RECIP_SHIFT + 2 +: Q400_W];

  // q100 is ceil(y / 100) in the century step. The year is a multiple of 100
  // exactly when 100 * q100 gives it back, and then a multiple of 400 when
  // q100 is a multiple of four.
  logic [MUL_A_W-1:0] cent_back;
  logic               div100, leap_d;

  assign cent_back = (MUL_A_W'(q100) << 6) + (MUL_A_W'(q100) << 5) + (MUL_A_W'(q100) << 2);
  assign div100    = (cent_back == {1'b0, cur_y});
  assign leap_d    = div100 ? (q100[1:0] == 2'b00) : (cur_y[1:0] == 2'b00);

  // Date check, used in the day step once the leap flag is known.
  logic date_ok;

  assign date_ok = (cur_m >= MONTH_FIRST) && (cur_m <= MONTH_LAST)
                && ({2'b00, cur_y} <= MaxYearW)
                && (cur_d != '0) && (cur_d <= month_len(cur_m, leap_q));

  // Month loop runs over months 1 up to the one before the date's month.
  logic month_more;

  assign month_more = (mcnt_q < cur_m) && (mcnt_q <= MONTH_LAST);

  // Shared accumulate adder. Date B enters with the opposite sign, so the sum
  // ends up as day number A minus day number B.
  logic [MUL_A_W-1:0]      y_plus3;
  logic [ACC_W-1:0]        addend;
  logic                    negate;

  assign y_plus3 = {1'b0, cur_y} + OFS_LEAP4;

  always_comb begin
    case (state_q)
      ST_YEAR:  addend = ACC_W'(prod_q);
      ST_CENT:  addend = ACC_W'(q100);
      ST_QUAD:  addend = ACC_W'(q400);
      ST_FOUR:  addend = ACC_W'(y_plus3[MUL_A_W-1:2]);
      ST_DAY:   addend = ACC_W'(cur_d);
      ST_MONTH: addend = month_more ? ACC_W'(month_len(mcnt_q, leap_q)) : '0;
      default:  addend = '0;
    endcase
  end

  assign negate = sel_b_q ^ (state_q == ST_CENT);
  assign acc_d  = negate ? (acc_q - $signed(addend)) : (acc_q + $signed(addend));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    sel_b_d = sel_b_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_MUL;
          sel_b_d = 1'b0;
        end
      end
      ST_MUL:  state_d = ST_YEAR;
      ST_YEAR: state_d = ST_CENT;
      ST_CENT: state_d = ST_QUAD;
      ST_QUAD: state_d = ST_FOUR;
      ST_FOUR: state_d = ST_DAY;
      ST_DAY:  state_d = ST_MONTH;
      ST_MONTH: begin
        if (!month_more) begin
          if (sel_b_q) begin
            state_d = ST_DONE;
          end else begin
            sel_b_d = 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_b_q     <= sel_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_k;
    if (in_beat) begin
      day_a_q   <= s_tdata_i[4:0];
      month_a_q <= s_tdata_i[8:5];
      year_a_q  <= s_tdata_i[22:9];
      day_b_q   <= s_tdata_i[27:23];
      month_b_q <= s_tdata_i[31:28];
      year_b_q  <= s_tdata_i[45:32];
      acc_q     <= '0;
    end else begin
      acc_q <= acc_d;
    end
    if (state_q == ST_CENT) begin
      leap_q <= leap_d;
    end
    if (state_q == ST_DAY) begin
      mcnt_q <= MONTH_FIRST;
      if (sel_b_q) begin
        valid_b_q <= date_ok;
      end else begin
        valid_a_q <= date_ok;
      end
    end else if ((state_q == ST_MONTH) && month_more) begin
      mcnt_q <= mcnt_q + 1'b1;
    end
  end

  // Saturation of the final count.
  logic              both_ok;
  logic [DIFF_W-1:0] diff_sat;

  assign both_ok = valid_a_q && valid_b_q;

  always_comb begin
    if (acc_q > DIFF_MAX) begin
      diff_sat = DIFF_MAX[DIFF_W-1:0];
    end else if (acc_q < DIFF_MIN) begin
      diff_sat = DIFF_MIN[DIFF_W-1:0];
    end else begin
      diff_sat = acc_q[DIFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_va_q   <= valid_a_q;
      out_vb_q   <= valid_b_q;
      out_diff_q <= both_ok ? diff_sat : '0;
      out_bef_q  <= both_ok && (acc_q < 0);
      out_aft_q  <= both_ok && (acc_q > 0);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {5'b00000, out_aft_q, out_bef_q, out_diff_q, out_vb_q, out_va_q};

  // An invalid date leaves the count and both order flags at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !(m_tdata_o[0] && m_tdata_o[1]) |-> (m_tdata_o[26:2] == '0))
    else $error("invalid date gave a nonzero result");

  // The order flags agree with the sign of the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[26] |-> !m_tdata_o[24] && !m_tdata_o[25] && (m_tdata_o[24:2] != '0))
    else $error("a_after_b disagrees with day_difference");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tdata_o[25] |-> m_tdata_o[24])
    else $error("a_before_b disagrees with day_difference");

  // An accepted request keeps the block busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> !s_tready_o)
    else $error("request taken while another is in work");

endmodule

/* tb/sv/gregorian_date_difference_tb.sv */
// Testbench of the Gregorian date difference block: directed and random requests, checked beat by beat.
`timescale 1ns / 1ps

module gregorian_date_difference_tb;
  import gdd_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Date A sits in the low bits of the request, date B above it.
  typedef struct packed {
    date_t date_b;
    date_t date_a;
  } request_t;

  typedef struct packed {
    logic                     a_after_b;
    logic                     a_before_b;
    logic signed [DIFF_W-1:0] day_difference;
    logic                     valid_b;
    logic                     valid_a;
  } outcome_t;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  localparam longint SPAN_MAX = (longint'(1) << (DIFF_W - 1)) - 1;
  localparam longint SPAN_MIN = -(longint'(1) << (DIFF_W - 1));

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid_i = 1'b0;
  logic                   s_tready_o;
  // Request: day_a, month_a, year_a, day_b, month_b, year_b, zero padding.
  logic [IN_TDATA_W-1:0]  s_tdata_i = '0;
  logic                   m_tvalid_o;
  logic                   m_tready_i = 1'b0;
  // Result: valid_a, valid_b, day_difference, a_before_b, a_after_b, zero padding.
  logic [OUT_TDATA_W-1:0] m_tdata_o;

  outcome_t    expected_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  gregorian_date_difference dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- calendar

  function automatic longint month_days(longint m, longint y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    if (m == 2) return leap ? 29 : 28;
    return 31;
  endfunction

  function automatic bit date_is_real(date_t dt);
    if (dt.month < 1 || dt.month > 12) return 1'b0;
    if (dt.year > DEF_MAX_YEAR) return 1'b0;
    return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
  endfunction

  // Days since the start of year zero, which counts as a leap year.
  function automatic longint day_ordinal(date_t dt);
    longint y;
    longint n;
    y = dt.year;
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int m = 1; m < dt.month; m++) n += month_days(m, y);
    return n + dt.day;
  endfunction

  function automatic outcome_t predict_outcome(request_t req);
    outcome_t o;
    longint   span;
    o.valid_a = date_is_real(req.date_a);
    o.valid_b = date_is_real(req.date_b);
    span = 0;
    if (o.valid_a && o.valid_b) begin
      span = day_ordinal(req.date_a) - day_ordinal(req.date_b);
      if (span > SPAN_MAX) span = SPAN_MAX;
      if (span < SPAN_MIN) span = SPAN_MIN;
    end
    o.day_difference = span[DIFF_W-1:0];
    o.a_before_b     = span < 0;
    o.a_after_b      = span > 0;
    return o;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic date_t cal_date(int unsigned d, int unsigned m, int unsigned y);
    date_t dt;
    dt.day   = d[DAY_W-1:0];
    dt.month = m[MONTH_W-1:0];
    dt.year  = y[YEAR_W-1:0];
    return dt;
  endfunction

  // A well-formed date leans on century and range edges now and then; a noisy
  // one takes every code the fields can carry.
  function automatic date_t random_date(bit noisy);
    date_t       dt;
    int unsigned y;
    int unsigned m;
    if (noisy) begin
      return cal_date($urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, (1 << YEAR_W) - 1));
    end
    case ($urandom_range(0, 7))
      0:       y = $urandom_range(0, 99) * 100;
      1:       y = $urandom_range(DEF_MAX_YEAR - 9, DEF_MAX_YEAR);
      2:       y = $urandom_range(0, 9);
      default: y = $urandom_range(0, DEF_MAX_YEAR);
    endcase
    m  = $urandom_range(1, 12);
    dt = cal_date($urandom_range(1, month_days(m, y)), m, y);
    return dt;
  endfunction

  function automatic request_t random_request();
    request_t req;
    req.date_a = random_date(1'b0);
    req.date_b = random_date(1'b0);
    case ($urandom_range(0, 19))
      0:       req.date_b = req.date_a;
      1, 2, 3: req.date_b.year = req.date_a.year;
      4, 5:    req.date_a = random_date(1'b1);
      6:       req.date_b = random_date(1'b1);
      7: begin
        req.date_a = random_date(1'b1);
        req.date_b = random_date(1'b1);
      end
      default: ;
    endcase
    return req;
  endfunction

  // Offers one request and waits for its beat to be taken. The sender runs in
  // bursts; valid only drops at the start of a gap, never around a beat.
  task automatic send_request(input request_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid_i <= 1'b0;
        s_tdata_i  <= IN_TDATA_W'({$urandom(), $urandom()});
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= IN_TDATA_W'(req);
    do @(posedge clk_i); while (!s_tready_o);
    expected_outcomes.push_back(predict_outcome(req));
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_cycles != 0) begin
      m_tready_i <= 1'b0;
      hold_cycles--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:     m_tready_i <= 1'b1;
        RX_COIN:     m_tready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE:   m_tready_i <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: m_tready_i <= (rx_tick % 7) < 3;
        default:     m_tready_i <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got = outcome_t'(m_tdata_o[$bits(outcome_t)-1:0]);
      if (expected_outcomes.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("valid_a", want.valid_a, got.valid_a);
        compare_field("valid_b", want.valid_b, got.valid_b);
        compare_field("day_difference", $signed(want.day_difference),
                      $signed(got.day_difference));
        compare_field("a_before_b", want.a_before_b, got.a_before_b);
        compare_field("a_after_b", want.a_after_b, got.a_after_b);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic send_pair(input date_t a, input date_t b);
    request_t req;
    req.date_a = a;
    req.date_b = b;
    send_request(req);
  endtask

  // Widest spans, equal dates and year zero.
  task automatic test_calendar_extremes();
    send_pair(cal_date(31, 12, DEF_MAX_YEAR), cal_date(1, 1, 0));
    send_pair(cal_date(1, 1, 0), cal_date(31, 12, DEF_MAX_YEAR));
    send_pair(cal_date(15, 6, 2024), cal_date(15, 6, 2024));
    send_pair(cal_date(29, 2, 0), cal_date(1, 3, 0));
    send_pair(cal_date(1, 1, 1), cal_date(31, 12, 0));
  endtask

  // Leap day in a 400-year century, a plain century, a plain leap year and a
  // common year.
  task automatic test_leap_rules();
    send_pair(cal_date(29, 2, 2000), cal_date(28, 2, 2000));
    send_pair(cal_date(29, 2, 1900), cal_date(1, 3, 1900));
    send_pair(cal_date(29, 2, 2004), cal_date(28, 2, 2003));
    send_pair(cal_date(29, 2, 2001), cal_date(1, 1, 2001));
    send_pair(cal_date(1, 3, 2100), cal_date(28, 2, 2100));
  endtask

  // Each way a date can fail, on either side, with every field bit set and
  // cleared along the way.
  task automatic test_invalid_dates();
    send_pair(cal_date(0, 5, 2010), cal_date(1, 5, 2010));
    send_pair(cal_date(31, 4, 2023), cal_date(30, 4, 2023));
    send_pair(cal_date(10, 0, 1999), cal_date(10, 1, 1999));
    send_pair(cal_date(10, 3, 1999), cal_date(10, 13, 1999));
    send_pair(cal_date(31, 15, 500), cal_date(31, 12, (1 << YEAR_W) - 1));
    send_pair(cal_date(1, 1, DEF_MAX_YEAR + 1), cal_date(1, 1, DEF_MAX_YEAR));
    send_pair(cal_date(0, 0, 0), cal_date(31, 15, (1 << YEAR_W) - 1));
    send_pair(cal_date(12, 7, 1776), cal_date(0, 7, 1776));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  // The receiver shuts off for a long stretch while requests keep coming, so
  // the output register fills and the input stalls.
  task automatic test_output_backpressure();
    repeat (2) begin
      hold_cycles = 500;
      repeat (80) send_request(random_request());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calendar_extremes();
    test_leap_rules();
    test_invalid_dates();
    test_random_traffic(1600);
    test_output_backpressure();

    s_tvalid_i <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
